// ----- src/lbs_pkg.sv -----
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types and constants for the linear blend vertex skinning engine.
// ----------------------------------------------------------------------------
package lbs_pkg;

  localparam int DEF_BONES = 64;
  localparam int WORD_W = 32;
  localparam int WORDS_PER_BONE = 12;
  localparam int ROWS_PER_BONE = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH = 2;
  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_SKIN = 1'b1;

  typedef struct packed {
    logic mode;
    logic err;
    logic signed [WORD_W-1:0] px;
    logic signed [WORD_W-1:0] py;
    logic signed [WORD_W-1:0] pz;
    logic [3:0][15:0] w;
    logic [3:0][7:0] bones;
    logic slot_ok;
    logic [7:0] row;
    logic [1:0] lane;
    logic signed [WORD_W-1:0] word;
  } item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] x;
    logic signed [WORD_W-1:0] y;
    logic signed [WORD_W-1:0] z;
    logic err;
    logic clip;
  } res_t;

endpackage

// ----- src/lbs_front.sv -----
// ----------------------------------------------------------------------------
// lbs_front
// Classifies incoming words: bone range check, weight clamp, slot decode.
// ----------------------------------------------------------------------------
module lbs_front import lbs_pkg::*; #(
  parameter int BONES = DEF_BONES
) (
  input  logic                     mode,
  input  logic signed [WORD_W-1:0] pos_x,
  input  logic signed [WORD_W-1:0] pos_y,
  input  logic signed [WORD_W-1:0] pos_z,
  input  logic [15:0]              weight_a,
  input  logic [15:0]              weight_b,
  input  logic [15:0]              weight_c,
  input  logic [15:0]              weight_d,
  input  logic [31:0]              bone_numbers,
  input  logic [9:0]               palette_slot,
  input  logic signed [WORD_W-1:0] palette_word,
  output item_t                    item
);

  logic [3:0][15:0] w_raw;
  logic [3:0] bad;

  assign w_raw = {weight_d, weight_c, weight_b, weight_a};

  always_comb begin
    item.mode = mode;
    item.px = pos_x;
    item.py = pos_y;
    item.pz = pos_z;
    item.bones = bone_numbers;
    for (int i = 0; i < 4; i++) begin
      item.w[i] = (w_raw[i] > ONE_Q15) ? ONE_Q15 : w_raw[i];
      bad[i] = {1'b0, bone_numbers[8*i +: 8]} >= 9'(BONES);
    end
    item.err = |bad;
    item.slot_ok = {2'b00, palette_slot} < 12'(BONES * WORDS_PER_BONE);
    item.row = palette_slot[9:2];
    item.lane = palette_slot[1:0];
    item.word = palette_word;
  end

endmodule

// ----- src/lbs_queue.sv -----
// ----------------------------------------------------------------------------
// lbs_queue
// Short in-order queue between the classifier and the execution unit.
// ----------------------------------------------------------------------------
module lbs_queue import lbs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output item_t head_item
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t slots [QUEUE_DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [PW:0] count;

  assign full = count == (PW+1)'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_item = slots[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wp] <= push_item;
    end
    if (rst) begin
      wp <= '0;
      rp <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (pop) begin
        rp <= rp + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ----- src/lbs_back.sv -----
// ----------------------------------------------------------------------------
// lbs_back
// Palette memory, row sequencer, blend datapath and result buffer.
// ----------------------------------------------------------------------------
module lbs_back import lbs_pkg::*; #(
  parameter int BONES = DEF_BONES
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  head_valid,
  input  item_t head_item,
  output logic  pop,
  output logic  res_valid,
  output res_t  res,
  input  logic  res_take
);

  localparam int PAL_ROWS = BONES * ROWS_PER_BONE;
  localparam int RW = (PAL_ROWS > 1) ? $clog2(PAL_ROWS) : 1;

  logic [3:0][WORD_W-1:0] pal [PAL_ROWS];
  logic [3:0][WORD_W-1:0] rdata;

  item_t cur;
  logic busy;
  logic [1:0] k;
  logic [1:0] r;
  logic [1:0] credit;
  logic last_step;
  logic start;
  logic we;
  logic [RW-1:0] raddr;

  logic v1, last1, err1;
  logic [1:0] k1, r1;
  logic signed [WORD_W-1:0] px1, py1, pz1;
  logic [15:0] w1;

  logic v2, last2, err2;
  logic [1:0] k2, r2;
  logic signed [63:0] p0, p1, p2;
  logic signed [WORD_W-1:0] t2;
  logic [15:0] w2;

  logic v3, last3, err3;
  logic [1:0] k3, r3;
  logic signed [49:0] s3;
  logic [15:0] w3;

  logic v4, last4, err4;
  logic [1:0] k4, r4;
  logic signed [66:0] m4;

  logic signed [53:0] acc [3];
  logic signed [66:0] m_rnd;
  logic signed [53:0] term;
  logic signed [53:0] fin [3];
  logic signed [49:0] s_sum;
  logic signed [63:0] q0, q1, q2;
  res_t res_new;
  logic res_push;

  res_t ob [OUT_DEPTH];
  logic ob_wp, ob_rp;
  logic [1:0] ob_cnt;

  assign last_step = cur.err || (k == 2'd3 && r == 2'd2);
  assign pop = !busy && head_valid &&
               (head_item.mode == MODE_WRITE || credit < 2'(OUT_DEPTH));
  assign start = pop && head_item.mode == MODE_SKIN;
  assign we = pop && head_item.mode == MODE_WRITE && head_item.slot_ok;
  assign raddr = RW'(10'(cur.bones[k]) * 10'd3 + 10'(r));

  always_ff @(posedge clk) begin
    if (we) begin
      pal[RW'(head_item.row)][head_item.lane] <= head_item.word;
    end
    if (busy && !cur.err) begin
      rdata <= pal[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cur <= head_item;
    end
    if (rst) begin
      busy <= 1'b0;
      k <= '0;
      r <= '0;
      credit <= '0;
    end else begin
      if (start) begin
        busy <= 1'b1;
        k <= '0;
        r <= '0;
      end else if (busy) begin
        if (last_step) begin
          busy <= 1'b0;
        end else if (r == 2'd2) begin
          r <= '0;
          k <= k + 1'b1;
        end else begin
          r <= r + 1'b1;
        end
      end
      credit <= credit + 2'(start) - 2'(res_take);
    end
  end

  always_comb begin
    q0 = (p0 + 64'sd32768) >>> 16;
    q1 = (p1 + 64'sd32768) >>> 16;
    q2 = (p2 + 64'sd32768) >>> 16;
    s_sum = 50'(q0) + 50'(q1) + 50'(q2) + 50'(t2);
    m_rnd = (m4 + 67'sd16384) >>> 15;
    term = m_rnd[53:0];
    for (int i = 0; i < 3; i++) begin
      fin[i] = acc[i];
    end
    fin[2] = acc[2] + term;
    res_new.err = err4;
    res_new.clip = 1'b0;
    res_new.x = '0;
    res_new.y = '0;
    res_new.z = '0;
    if (!err4) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [WORD_W-1:0] sat;
        if (fin[i] > 54'sd2147483647) begin
          sat = 32'sh7fffffff;
          res_new.clip = 1'b1;
        end else if (fin[i] < -54'sd2147483648) begin
          sat = 32'sh80000000;
          res_new.clip = 1'b1;
        end else begin
          sat = fin[i][31:0];
        end
        case (i)
          0: res_new.x = sat;
          1: res_new.y = sat;
          default: res_new.z = sat;
        endcase
      end
    end
    res_push = v4 && last4;
  end

  always_ff @(posedge clk) begin
    px1 <= cur.px;
    py1 <= cur.py;
    pz1 <= cur.pz;
    w1 <= cur.w[k];
    k1 <= k;
    r1 <= r;
    last1 <= last_step;
    err1 <= cur.err;

    p0 <= $signed(rdata[0]) * px1;
    p1 <= $signed(rdata[1]) * py1;
    p2 <= $signed(rdata[2]) * pz1;
    t2 <= $signed(rdata[3]);
    w2 <= w1;
    k2 <= k1;
    r2 <= r1;
    last2 <= last1;
    err2 <= err1;

    s3 <= s_sum;
    w3 <= w2;
    k3 <= k2;
    r3 <= r2;
    last3 <= last2;
    err3 <= err2;

    m4 <= s3 * $signed({1'b0, w3});
    k4 <= k3;
    r4 <= r3;
    last4 <= last3;
    err4 <= err3;

    if (v4 && !err4) begin
      if (k4 == 2'd0) begin
        acc[r4] <= term;
      end else begin
        acc[r4] <= acc[r4] + term;
      end
    end
    if (res_push) begin
      ob[ob_wp] <= res_new;
    end

    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      ob_wp <= 1'b0;
      ob_rp <= 1'b0;
      ob_cnt <= '0;
    end else begin
      v1 <= busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      if (res_push) begin
        ob_wp <= ~ob_wp;
      end
      if (res_take) begin
        ob_rp <= ~ob_rp;
      end
      ob_cnt <= ob_cnt + 2'(res_push) - 2'(res_take);
    end
  end

  assign res_valid = ob_cnt != '0;
  assign res = ob[ob_rp];

endmodule

// ----- src/linear_blend_vertex_skinning.sv -----
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning
// Four-bone linear blend skinning engine with a writable bone palette.
// Each skin word yields one result word, flagged when a bone number is out of
// range; palette writes return nothing.
// Skin words are sequenced one at a time through the single palette read port
// delivering one of the twelve matrix rows per cycle; a word with a bad bone
// number reads no rows, and a palette write does not occupy the sequencer.
// Reset clears the control state; palette contents are kept and undefined.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning import lbs_pkg::*; #(
  parameter int BONES = DEF_BONES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     mode,
  input  logic signed [WORD_W-1:0] pos_x,
  input  logic signed [WORD_W-1:0] pos_y,
  input  logic signed [WORD_W-1:0] pos_z,
  input  logic [15:0]              weight_a,
  input  logic [15:0]              weight_b,
  input  logic [15:0]              weight_c,
  input  logic [15:0]              weight_d,
  input  logic [31:0]              bone_numbers,
  input  logic [9:0]               palette_slot,
  input  logic signed [WORD_W-1:0] palette_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [WORD_W-1:0] out_x,
  output logic signed [WORD_W-1:0] out_y,
  output logic signed [WORD_W-1:0] out_z,
  output logic                     bone_error,
  output logic                     clipped
);

  item_t in_item;
  item_t head_item;
  logic full;
  logic head_valid;
  logic pop;
  res_t res;

  lbs_front #(.BONES(BONES)) u_front (
    .mode(mode), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
    .weight_d(weight_d), .bone_numbers(bone_numbers),
    .palette_slot(palette_slot), .palette_word(palette_word),
    .item(in_item)
  );

  lbs_queue u_queue (
    .clk(clk), .rst(rst),
    .push(in_valid && !full), .push_item(in_item), .full(full),
    .pop(pop), .head_valid(head_valid), .head_item(head_item)
  );

  lbs_back #(.BONES(BONES)) u_back (
    .clk(clk), .rst(rst),
    .head_valid(head_valid), .head_item(head_item), .pop(pop),
    .res_valid(out_valid), .res(res), .res_take(out_valid && !out_stall)
  );

  assign in_stall = full;
  assign out_x = res.x;
  assign out_y = res.y;
  assign out_z = res.z;
  assign bone_error = res.err;
  assign clipped = res.clip;

endmodule

// ----- src/lbs_checker.sv -----
// ----------------------------------------------------------------------------
// lbs_checker
// Port-level checks for the skinning engine, bound to the top level.
// ----------------------------------------------------------------------------
module lbs_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_x,
  input logic [31:0] out_y,
  input logic [31:0] out_z,
  input logic        bone_error,
  input logic        clipped
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Result word dropped while stalled.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Result word shown right after reset.");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bone_error |->
      out_x == 32'h0 && out_y == 32'h0 && out_z == 32'h0 && !clipped)
    else $error("Bone error word carries nonzero data.");

  a_clip_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      out_x == 32'h7fffffff || out_x == 32'h80000000 ||
      out_y == 32'h7fffffff || out_y == 32'h80000000 ||
      out_z == 32'h7fffffff || out_z == 32'h80000000)
    else $error("Clipped flag without a saturated coordinate.");

endmodule

bind linear_blend_vertex_skinning lbs_checker u_lbs_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_stall(out_stall),
  .out_x(out_x), .out_y(out_y), .out_z(out_z),
  .bone_error(bone_error), .clipped(clipped)
);
